// ===== hdl/sse_pkg.sv =====
`timescale 1ns / 1ps

package sse_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DUMP_MAX     = 32;
  localparam int CMD_W        = 2;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_cmd;     // latch the accepted transaction
    logic do_exec;     // apply the command and emit its single result
    logic dump_start;  // rewind the dump index
    logic dump_emit;   // emit the element under the dump index
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic out_free;
    logic occ_zero;
    logic dump_last;
  } stat_t;

endpackage

// ===== hdl/sse_if.sv =====
`timescale 1ns / 1ps

interface sse_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [sse_pkg::CMD_W-1:0]           cmd;
  logic signed [sse_pkg::VAL_W-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sse_res_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic                                full_res;
  logic signed [sse_pkg::VAL_W-1:0]    element;
  logic                                element_valid;
  logic                                last;
  logic [sse_pkg::CNT_W-1:0]           count;

  modport source (output valid, output ok, output full_res, output element,
                  output element_valid, output last, output count, input ready);
  modport sink   (input valid, input ok, input full_res, input element,
                  input element_valid, input last, input count, output ready);
endinterface

// ===== hdl/sse_ctrl.sv =====
`timescale 1ns / 1ps

module sse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sse_pkg::stat_t  stat_i,
  output sse_pkg::ctrl_t  ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cap_cmd = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          if (stat_i.cmd == sse_pkg::CMD_DUMP && !stat_i.occ_zero) begin
            ctrl_o.dump_start = 1'b1;
            state_d           = S_DUMP;
          end else begin
            ctrl_o.do_exec = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (stat_i.out_free) begin
          ctrl_o.dump_emit = 1'b1;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/sse_dp.sv =====
`timescale 1ns / 1ps

module sse_dp #(
  parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sse_pkg::ctrl_t                    ctrl_i,
  output sse_pkg::stat_t                    stat_o,
  input  logic [sse_pkg::CMD_W-1:0]         in_cmd_i,
  input  logic signed [sse_pkg::VAL_W-1:0]  in_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_ok_o,
  output logic                              out_full_o,
  output logic signed [sse_pkg::VAL_W-1:0]  out_element_o,
  output logic                              out_element_valid_o,
  output logic                              out_last_o,
  output logic [sse_pkg::CNT_W-1:0]         out_count_o
);

  localparam int OCC_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int DUMP_N_MAX = (CAPACITY < sse_pkg::DUMP_MAX) ? CAPACITY : sse_pkg::DUMP_MAX;
  localparam int EXT_W      = OCC_W + sse_pkg::CNT_W;

  sse_pkg::cmd_e                    cmd_q;
  logic signed [sse_pkg::VAL_W-1:0] val_q;
  logic signed [sse_pkg::VAL_W-1:0] cell_q [CAPACITY];
  logic [OCC_W-1:0]                 occ_q, occ_d;
  logic [IDX_W-1:0]                 dump_idx_q;

  logic [CAPACITY-1:0] lt, eq;
  logic [CAPACITY:0]   lt_ext;
  logic                hit, full, ins_ok, del_ok, srch_ok, emit;
  logic [OCC_W-1:0]    dump_n;
  logic [EXT_W-1:0]    cnt_ext_next, cnt_ext_cur;

  logic                              out_valid_q;
  logic                              out_ok_q, out_full_q, out_ev_q, out_last_q;
  logic signed [sse_pkg::VAL_W-1:0]  out_elem_q;
  logic [sse_pkg::CNT_W-1:0]         out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_cmd) begin
      cmd_q <= sse_pkg::cmd_e'(in_cmd_i);
      val_q <= in_value_i;
    end
  end

  // Every occupied cell compares against the key at once. The cells are kept
  // sorted, so lt forms a thermometer code whose edge is the insert position.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (OCC_W'(i) < occ_q) && (cell_q[i] < val_q);
      eq[i] = (OCC_W'(i) < occ_q) && (cell_q[i] == val_q);
    end
    lt_ext = {lt, 1'b1};
  end

  assign hit     = |eq;
  assign full    = (occ_q == OCC_W'(CAPACITY));
  assign ins_ok  = (cmd_q == sse_pkg::CMD_INSERT) && !hit && !full;
  assign del_ok  = (cmd_q == sse_pkg::CMD_DELETE) && hit;
  assign srch_ok = (cmd_q == sse_pkg::CMD_SEARCH) && hit;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ctrl_i.do_exec && !lt[g]) begin
        if (ins_ok) begin
          if (g == 0) begin
            cell_q[g] <= val_q;
          end else begin
            cell_q[g] <= lt_ext[g] ? val_q : cell_q[(g > 0) ? g - 1 : 0];
          end
        end else if (del_ok && g < CAPACITY - 1) begin
          cell_q[g] <= cell_q[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.do_exec) begin
      if (ins_ok) begin
        occ_d = occ_q + OCC_W'(1);
      end else if (del_ok) begin
        occ_d = occ_q - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign dump_n = (occ_q > OCC_W'(DUMP_N_MAX)) ? OCC_W'(DUMP_N_MAX) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_idx_q <= '0;
    end else if (ctrl_i.dump_start) begin
      dump_idx_q <= '0;
    end else if (ctrl_i.dump_emit) begin
      dump_idx_q <= dump_idx_q + IDX_W'(1);
    end
  end

  assign cnt_ext_next = EXT_W'(occ_d);
  assign cnt_ext_cur  = EXT_W'(occ_q);
  assign emit         = ctrl_i.do_exec || ctrl_i.dump_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_exec) begin
      out_ok_q   <= ins_ok || del_ok || srch_ok;
      out_full_q <= (cmd_q == sse_pkg::CMD_INSERT) && !hit && full;
      out_elem_q <= '0;
      out_ev_q   <= 1'b0;
      out_last_q <= 1'b1;
      out_cnt_q  <= cnt_ext_next[sse_pkg::CNT_W-1:0];
    end else if (ctrl_i.dump_emit) begin
      out_ok_q   <= 1'b0;
      out_full_q <= 1'b0;
      out_elem_q <= cell_q[dump_idx_q];
      out_ev_q   <= 1'b1;
      out_last_q <= stat_o.dump_last;
      out_cnt_q  <= cnt_ext_cur[sse_pkg::CNT_W-1:0];
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.occ_zero  = (occ_q == '0);
  assign stat_o.dump_last = ((OCC_W'(dump_idx_q) + OCC_W'(1)) == dump_n);

  assign out_valid_o         = out_valid_q;
  assign out_ok_o            = out_ok_q;
  assign out_full_o          = out_full_q;
  assign out_element_o       = out_elem_q;
  assign out_element_valid_o = out_ev_q;
  assign out_last_o          = out_last_q;
  assign out_count_o         = out_cnt_q;

endmodule

// ===== hdl/sorted_set_engine_core.sv =====
`timescale 1ns / 1ps
// Insert, delete and search are accepted in S_IDLE; in S_EXEC, once the output register is
// free, all cells compare in parallel, shift and load it; then S_IDLE takes a new one.
// A dump gives one result per stored value (at most 32 results), one element per cycle
// from the cell array while the output register is free; an empty dump gives one result.
// Reset (rst_ni low, asynchronous) empties the set and clears the handshake state; the
// cell contents are not cleared and are never read before they are written.

module sorted_set_engine_core #(
  parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sse_cmd_if.sink     req_i,
  sse_res_if.source   rsp_o
);

  // The controller sequences each command and the datapath holds the sorted
  // cells, the occupancy and the output register. They meet only through
  // these two structs.
  sse_pkg::ctrl_t ctrl;
  sse_pkg::stat_t stat;

  sse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The output register decouples the result side, so a command can be
  // accepted while the previous result still waits for its transaction.
  sse_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .in_cmd_i            (req_i.cmd),
    .in_value_i          (req_i.value),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .out_ok_o            (rsp_o.ok),
    .out_full_o          (rsp_o.full_res),
    .out_element_o       (rsp_o.element),
    .out_element_valid_o (rsp_o.element_valid),
    .out_last_o          (rsp_o.last),
    .out_count_o         (rsp_o.count)
  );

`ifndef ASSERT_OFF
  // Only one command is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("command accepted while another is in progress");

  // A refused insert neither succeeds nor carries an element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.full_res |-> !rsp_o.ok && !rsp_o.element_valid && rsp_o.last)
    else $error("full result with inconsistent flags");

  // Dump elements never report a status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.element_valid |-> !rsp_o.ok && !rsp_o.full_res)
    else $error("dump element with status flags set");

  // Only a dump produces more than one result per command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.last |-> rsp_o.element_valid)
    else $error("non-final result that is not a dump element");
`endif

endmodule

// ===== tb/sorted_set_engine_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted set engine. A mirror of the set, kept as a sorted
// queue, predicts every result of every accepted command, and each result that leaves
// the block is compared field by field with the oldest prediction still outstanding.
module sorted_set_engine_core_tb;

  localparam int CAP            = sse_pkg::CAPACITY_DEF;
  localparam int POOL_SIZE      = 48;            // more distinct keys than the set can hold
  localparam int DRAIN_TAIL     = sse_pkg::DUMP_MAX + 8;  // a full dump plus the pipeline
  localparam int WATCHDOG_LIMIT = 2000;          // cycles without any transaction
  localparam int HOLD_CYCLES    = 150;           // long receiver hold-off in the first phase

  typedef struct packed {
    logic                             ok;
    logic                             full_res;
    logic signed [sse_pkg::VAL_W-1:0] element;
    logic                             element_valid;
    logic                             last;
    logic [sse_pkg::CNT_W-1:0]        count;
  } set_result_t;

  // Mirror of the stored set plus the queue of results that are still owed by the block.
  class set_tracker;
    logic signed [sse_pkg::VAL_W-1:0] members[$];
    set_result_t                      awaited[$];
    int                               capacity;
    int                               mismatches;

    function new(int cap);
      capacity   = cap;
      mismatches = 0;
    endfunction

    // Apply one accepted command to the mirror and queue the results it must produce.
    function void note_command(sse_pkg::cmd_e op, logic signed [sse_pkg::VAL_W-1:0] key);
      set_result_t r;
      int          pos;
      int          n;
      int          i;
      bit          hit;
      r      = '{default: '0};
      r.last = 1'b1;
      if (op == sse_pkg::CMD_DUMP) begin
        n       = (members.size() > sse_pkg::DUMP_MAX) ? sse_pkg::DUMP_MAX : members.size();
        r.count = sse_pkg::CNT_W'(members.size());
        if (n == 0) begin
          awaited.push_back(r);
        end else begin
          for (i = 0; i < n; i++) begin
            r.element       = members[i];
            r.element_valid = 1'b1;
            r.last          = (i == n - 1);
            awaited.push_back(r);
          end
        end
        return;
      end
      // Lower bound: first slot whose value is not below the key, in signed order.
      pos = 0;
      while (pos < members.size() && members[pos] < key) pos++;
      hit = (pos < members.size()) && (members[pos] == key);
      case (op)
        sse_pkg::CMD_INSERT: begin
          // A present key is a duplicate even when the set is full.
          if (hit) begin
            r.ok = 1'b0;
          end else if (members.size() >= capacity) begin
            r.full_res = 1'b1;
          end else begin
            members.insert(pos, key);
            r.ok = 1'b1;
          end
        end
        sse_pkg::CMD_DELETE: begin
          if (hit) begin
            members.delete(pos);
            r.ok = 1'b1;
          end
        end
        default: begin
          r.ok = hit;
        end
      endcase
      r.count = sse_pkg::CNT_W'(members.size());
      awaited.push_back(r);
    endfunction

    function void check_field(string field_name, logic [sse_pkg::VAL_W-1:0] exp_v,
                              logic [sse_pkg::VAL_W-1:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field_name, exp_v, act_v);
      end
    endfunction

    function void check_result(set_result_t got);
      set_result_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got element %0h count %0d",
                 $time, got.element, got.count);
        return;
      end
      exp = awaited.pop_front();
      check_field("ok", exp.ok, got.ok);
      check_field("full_res", exp.full_res, got.full_res);
      check_field("element", exp.element, got.element);
      check_field("element_valid", exp.element_valid, got.element_valid);
      check_field("last", exp.last, got.last);
      check_field("count", exp.count, got.count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sse_cmd_if req_if ();
  sse_res_if rsp_if ();

  sorted_set_engine_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  set_tracker tracker = new(CAP);

  // Traffic shaping knobs. The percentages and the hold-off request are only changed right
  // after a rising edge, so the receiver process, which runs on the falling edge, never
  // races with the main sequence over them. A new hold-off is requested by bumping
  // hold_seq; the receiver then loads hold_len into its own counter.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_len       = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int idle_run       = 0;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver side: either a counted hold-off or a random stall on each cycle.
  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left    = hold_left - 1;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Observe both channels at the rising edge. The watchdog counts cycles in which neither
  // channel completes a transaction, which also catches a block that hangs at the end.
  always @(posedge clk_i) begin
    set_result_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.ok            = rsp_if.ok;
        got.full_res      = rsp_if.full_res;
        got.element       = rsp_if.element;
        got.element_valid = rsp_if.element_valid;
        got.last          = rsp_if.last;
        got.count         = rsp_if.count;
        tracker.check_result(got);
      end
      if (req_if.valid && req_if.ready) begin
        tracker.note_command(sse_pkg::cmd_e'(req_if.cmd), req_if.value);
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        idle_run = 0;
      end else begin
        idle_run = idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, idle_run);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Called and left on a falling edge. Valid stays high after the transaction so that a
  // back-to-back command does not drop it in between.
  task automatic send_cmd(sse_pkg::cmd_e op, logic signed [sse_pkg::VAL_W-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.cmd   = op;
    req_if.value = key;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Sender pause: nothing is offered until every owed result has left the block.
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  // A fixed pool of distinct keys, extremes included, so that hits and a full set are
  // common. The spacing keeps the ordinary entries apart from zero and minus one.
  function automatic logic signed [sse_pkg::VAL_W-1:0] pool_value(int idx);
    case (idx)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return sse_pkg::VAL_W'(idx * 1000 - 24007);
    endcase
  endfunction

  // Keys come from the pool, from the set itself (more often for deletes and searches, so
  // that they hit), and otherwise from the whole 32-bit range.
  function automatic logic signed [sse_pkg::VAL_W-1:0] pick_value(bit favor_present);
    int r;
    r = $urandom_range(99);
    if (tracker.members.size() != 0 && r < (favor_present ? 50 : 15)) begin
      return tracker.members[$urandom_range(tracker.members.size() - 1)];
    end
    if (r < 80) return pool_value($urandom_range(POOL_SIZE - 1));
    return $urandom;
  endfunction

  // One traffic phase: a run of consecutive pool inserts that fills the set when it is
  // long enough, a dump, then mixed commands steered by how full the set is.
  task automatic run_phase(int src_pct, int sink_pct, int hold, int fill_len,
                           int n_items);
    int            sent;
    int            start;
    int            k;
    int            r;
    int            ins_w;
    int            del_w;
    sse_pkg::cmd_e op;
    @(posedge clk_i);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    hold_len       = hold;
    hold_seq       = hold_seq + 1;
    @(negedge clk_i);
    start = $urandom_range(POOL_SIZE - 1);
    for (k = 0; k < fill_len; k++) begin
      send_cmd(sse_pkg::CMD_INSERT, pool_value((start + k) % POOL_SIZE));
    end
    send_cmd(sse_pkg::CMD_DUMP, $urandom);
    sent = fill_len + 1;
    while (sent < n_items) begin
      // Lean toward deletes when the set is nearly full and toward inserts when nearly
      // empty, so the occupancy keeps sweeping its whole range.
      if (tracker.members.size() > CAP - 8) begin
        ins_w = 30;
        del_w = 45;
      end else if (tracker.members.size() < 8) begin
        ins_w = 55;
        del_w = 20;
      end else begin
        ins_w = 38;
        del_w = 32;
      end
      r = $urandom_range(99);
      if (r < ins_w) op = sse_pkg::CMD_INSERT;
      else if (r < ins_w + del_w) op = sse_pkg::CMD_DELETE;
      else if (r < 92) op = sse_pkg::CMD_SEARCH;
      else op = sse_pkg::CMD_DUMP;
      send_cmd(op, (op == sse_pkg::CMD_DUMP) ? $urandom :
                   pick_value(op != sse_pkg::CMD_INSERT));
      sent++;
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.cmd    = sse_pkg::CMD_INSERT;
    req_if.value  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty set, extremes of the key range, duplicates, misses next to
    // stored neighbors, and dumps of an empty and of a populated set.
    send_cmd(sse_pkg::CMD_DUMP, 32'sd0);
    send_cmd(sse_pkg::CMD_SEARCH, 32'sd0);
    send_cmd(sse_pkg::CMD_DELETE, 32'sd5);
    send_cmd(sse_pkg::CMD_INSERT, 32'sh8000_0000);
    send_cmd(sse_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
    send_cmd(sse_pkg::CMD_INSERT, 32'sd0);
    send_cmd(sse_pkg::CMD_INSERT, -32'sd1);
    send_cmd(sse_pkg::CMD_INSERT, 32'sh8000_0000);
    send_cmd(sse_pkg::CMD_SEARCH, 32'sh7FFF_FFFF);
    send_cmd(sse_pkg::CMD_SEARCH, 32'sd1);
    send_cmd(sse_pkg::CMD_SEARCH, 32'sh8000_0000);
    send_cmd(sse_pkg::CMD_DUMP, 32'shFFFF_FFFF);
    send_cmd(sse_pkg::CMD_DELETE, 32'sh7FFF_FFFF);
    send_cmd(sse_pkg::CMD_DELETE, 32'sh7FFF_FFFF);
    send_cmd(sse_pkg::CMD_INSERT, 32'sh7FFF_FFFE);
    send_cmd(sse_pkg::CMD_SEARCH, 32'sh7FFF_FFFF);
    send_cmd(sse_pkg::CMD_INSERT, 32'sd1);
    send_cmd(sse_pkg::CMD_DUMP, 32'sh5555_AAAA);
    send_cmd(sse_pkg::CMD_DELETE, 32'sh8000_0000);
    send_cmd(sse_pkg::CMD_DELETE, -32'sd1);
    send_cmd(sse_pkg::CMD_DELETE, 32'sd0);
    send_cmd(sse_pkg::CMD_DELETE, 32'sd1);
    send_cmd(sse_pkg::CMD_DELETE, 32'sh7FFF_FFFE);
    send_cmd(sse_pkg::CMD_DUMP, 32'sd0);
    wait_drained();

    // Random part. The first phase starts with the receiver held off while a long run of
    // inserts is offered, so the block backs up, and that run overfills the set to reach
    // the full case.
    run_phase(0, 0, HOLD_CYCLES, 36, 60);
    run_phase(70, 0, 0, $urandom_range(12, 36), 60);
    run_phase(0, 70, 0, 36, 60);
    run_phase(31, 31, 0, $urandom_range(12, 36), 60);

    if (tracker.awaited.size() != 0) begin
      tracker.mismatches++;
      $display("%0t: results missing, expected %0d more, got none",
               $time, tracker.awaited.size());
    end
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
